### hdl/bch_pkg.sv
// Shared types, constants and GF(2) helper functions for the BCH(15,7) codec.
// No dependencies; imported by every module of the codec.
package bch_pkg;

    localparam int unsigned N         = 15;
    localparam int unsigned K         = 7;
    localparam int unsigned M         = 8;
    localparam int unsigned T_CORRECT = 2;
    localparam logic [M:0]  GEN_POLY  = 9'h1D1;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef logic [N-1:0] t_word;
    typedef logic [M-1:0] t_rem;
    typedef logic [K-1:0] t_data;

    typedef struct packed {
        t_op   op;
        t_word word;
    } t_in_item;

    typedef struct packed {
        t_word result;
        logic  failed;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        t_word            word;
        t_rem [N-1:0]     rem;
        logic [N-1:0]     ok;
    } t_syn_item;

    typedef struct packed {
        t_op   op;
        t_word word;
        logic  failed;
    } t_fix_item;

    function automatic t_word rot_left(t_word w, int unsigned s);
        logic [2*N-1:0] d;
        d = {w, w} << s;
        return d[2*N-1:N];
    endfunction

    function automatic t_word rot_right(t_word w, int unsigned s);
        logic [2*N-1:0] d;
        d = {w, w} >> s;
        return d[N-1:0];
    endfunction

    function automatic t_rem gf2_rem(t_word w);
        t_word r;
        r = w;
        for (int i = K - 1; i >= 0; i--) begin
            if (r[i+M]) begin
                r = r ^ (t_word'(GEN_POLY) << i);
            end
        end
        return r[M-1:0];
    endfunction

    function automatic t_data gf2_quot(t_word w);
        t_word r;
        t_data q;
        r = w;
        q = '0;
        for (int i = K - 1; i >= 0; i--) begin
            if (r[i+M]) begin
                q[i] = 1'b1;
                r = r ^ (t_word'(GEN_POLY) << i);
            end
        end
        return q;
    endfunction

    function automatic t_word gf2_mul(t_data d);
        t_word acc;
        acc = '0;
        for (int i = 0; i < K; i++) begin
            if (d[i]) begin
                acc = acc ^ (t_word'(GEN_POLY) << i);
            end
        end
        return acc;
    endfunction

    function automatic logic low_weight(t_rem r);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < M; i++) begin
            c = c + 4'(r[i]);
        end
        return c <= 4'(T_CORRECT);
    endfunction

endpackage

### hdl/bch_15_7_codec.sv
// BCH(15,7) t=2 codec: encode by generator product, decode by error trapping.
// Three register stages lie between input transfer and output valid: bch_syn, bch_trap, bch_out.
// Throughput: one item per cycle when not stalled; a stall holds every full stage in place.
// Reset: synchronous active-low i_rst_n clears the stage valid bits only.
// Depends on bch_pkg, bch_syn, bch_trap, bch_out.
module bch_15_7_codec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bch_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bch_pkg::t_out_item o_out_data
);
    import bch_pkg::*;

    logic      syn_vld;
    logic      syn_rdy;
    t_syn_item syn_data;
    logic      fix_vld;
    logic      fix_rdy;
    t_fix_item fix_data;

    bch_syn u_syn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_data  (i_in_data),
        .o_vld   (syn_vld),
        .i_rdy   (syn_rdy),
        .o_data  (syn_data)
    );

    bch_trap u_trap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (syn_vld),
        .o_rdy   (syn_rdy),
        .i_data  (syn_data),
        .o_vld   (fix_vld),
        .i_rdy   (fix_rdy),
        .o_data  (fix_data)
    );

    bch_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fix_vld),
        .o_rdy   (fix_rdy),
        .i_data  (fix_data),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

### hdl/bch_syn.sv
// Stage 1: remainder of every cyclic rotation of the word and its weight test.
// Depends on bch_pkg.
module bch_syn (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  bch_pkg::t_in_item  i_data,
    output logic               o_vld,
    input  logic               i_rdy,
    output bch_pkg::t_syn_item o_data
);
    import bch_pkg::*;

    logic      r_vld;
    t_syn_item r_data;
    t_syn_item n_data;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        n_data.op   = i_data.op;
        n_data.word = i_data.word;
        for (int s = 0; s < N; s++) begin
            n_data.rem[s] = gf2_rem(rot_left(i_data.word, s));
            n_data.ok[s]  = low_weight(n_data.rem[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

`ifndef SYNTHESIS
    a_zero_rem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_data.rem[0] == '0 |-> r_data.ok[0])
        else $error("zero remainder not flagged as trappable");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_rdy |=> r_vld && $stable(r_data))
        else $error("stage 1 lost data under stall");
`endif

endmodule

### hdl/bch_trap.sv
// Stage 2: pick the first trapping rotation and correct the received word.
// Depends on bch_pkg.
module bch_trap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  bch_pkg::t_syn_item i_data,
    output logic               o_vld,
    input  logic               i_rdy,
    output bch_pkg::t_fix_item o_data
);
    import bch_pkg::*;

    logic      r_vld;
    t_fix_item r_data;
    t_fix_item n_data;
    t_word     err;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        err = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (i_data.ok[s]) begin
                err = rot_right(t_word'(i_data.rem[s]), s);
            end
        end
        n_data.op     = i_data.op;
        n_data.failed = (i_data.op == OP_DECODE) && (i_data.ok == '0);
        n_data.word   = (i_data.op == OP_DECODE) ? (i_data.word ^ err) : i_data.word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

`ifndef SYNTHESIS
    a_fail_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_data.failed |-> r_data.op == OP_DECODE)
        else $error("failure flagged on encode");
`endif

endmodule

### hdl/bch_out.sv
// Stage 3: quotient of the corrected word or product for encode; output register.
// Depends on bch_pkg.
module bch_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  bch_pkg::t_fix_item i_data,
    output logic               o_vld,
    input  logic               i_rdy,
    output bch_pkg::t_out_item o_data
);
    import bch_pkg::*;

    logic      r_vld;
    t_out_item r_data;
    t_out_item n_data;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        if (i_data.op == OP_ENCODE) begin
            n_data.result = gf2_mul(i_data.word[K-1:0]);
        end else if (i_data.failed) begin
            n_data.result = '0;
        end else begin
            n_data.result = t_word'(gf2_quot(i_data.word));
        end
        n_data.failed = i_data.failed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_data.failed |-> r_data.result == '0)
        else $error("failed result is not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_rdy |=> r_vld && $stable(r_data))
        else $error("output register changed under stall");
`endif

endmodule

### tb/bch_codec_checker.sv
// Transfer checker for the BCH(15,7) codec: predicts every result from the input transfers
// and compares it against the output transfers in order. Depends on bch_pkg.
module bch_codec_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bch_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bch_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_encodes,
    output int                 o_decodes,
    output int                 o_uncorrectable
);
    timeunit 1ns;
    timeprecision 1ps;

    import bch_pkg::*;

    t_out_item answers [$];

    function automatic t_word encode_word(t_data d);
        t_word acc;
        acc = '0;
        for (int j = 0; j <= M; j++) begin
            if (GEN_POLY[j]) begin
                acc = acc ^ (t_word'(d) << j);
            end
        end
        return acc;
    endfunction

    function automatic t_rem divide_by_gen(input t_word w, output t_data quot);
        t_word r;
        r = w;
        quot = '0;
        for (int i = K - 1; i >= 0; i--) begin
            if (r[i+M]) begin
                quot[i] = 1'b1;
                r = r ^ (t_word'(GEN_POLY) << i);
            end
        end
        return t_rem'(r);
    endfunction

    function automatic t_word rotate_left(t_word w, int unsigned s);
        if (s % N == 0) begin
            return w;
        end
        return (w << (s % N)) | (w >> (N - s % N));
    endfunction

    function automatic t_out_item codec_answer(t_in_item it);
        t_out_item ans;
        t_rem      rem;
        t_data     quot;
        t_word     turned;
        ans = '0;
        if (it.op == OP_ENCODE) begin
            ans.result = encode_word(it.word[K-1:0]);
        end else begin
            rem = divide_by_gen(it.word, quot);
            if (rem == '0) begin
                ans.result = t_word'(quot);
            end else begin
                ans.failed = 1'b1;
                for (int s = 0; s < N; s++) begin
                    turned = rotate_left(it.word, s);
                    rem = divide_by_gen(turned, quot);
                    if ($countones(rem) <= T_CORRECT) begin
                        rem = divide_by_gen(rotate_left(turned ^ t_word'(rem), N - s), quot);
                        ans.result = t_word'(quot);
                        ans.failed = 1'b0;
                        break;
                    end
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : p_check
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            answers.delete();
            o_fail_count    <= 0;
            o_pending       <= 0;
            o_encodes       <= 0;
            o_decodes       <= 0;
            o_uncorrectable <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                want = codec_answer(i_in_data);
                answers.push_back(want);
                if (i_in_data.op == OP_ENCODE) begin
                    o_encodes <= o_encodes + 1;
                end else begin
                    o_decodes <= o_decodes + 1;
                    if (want.failed) begin
                        o_uncorrectable <= o_uncorrectable + 1;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected transfer: result %h failed %b",
                           i_out_data.result, i_out_data.failed);
                    errs++;
                end else begin
                    want = answers.pop_front();
                    if (i_out_data.result !== want.result) begin
                        $error("result: expected %h, actual %h", want.result,
                               i_out_data.result);
                        errs++;
                    end
                    if (i_out_data.failed !== want.failed) begin
                        $error("failed: expected %b, actual %b", want.failed,
                               i_out_data.failed);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= answers.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for bch_15_7_codec: clock, reset, directed and random stimulus,
// receiver stalls and the verdict. Depends on bch_pkg, bch_15_7_codec and bch_codec_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bch_pkg::*;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_BURSTS
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int encodes;
    int decodes;
    int uncorrectable;
    int idle_cycles = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    logic        hold_val   = 1'b0;

    always #5 clk = ~clk;

    bch_15_7_codec u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item)
    );

    bch_codec_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_encodes       (encodes),
        .o_decodes       (decodes),
        .o_uncorrectable (uncorrectable)
    );

    function automatic t_word codeword(t_data d);
        t_word acc;
        acc = '0;
        for (int i = 0; i < K; i++) begin
            if (d[i]) begin
                acc = acc ^ (t_word'(GEN_POLY) << i);
            end
        end
        return acc;
    endfunction

    function automatic t_word error_mask(int unsigned bits);
        t_word m;
        m = '0;
        while ($countones(m) < bits) begin
            m[$urandom_range(0, N - 1)] = 1'b1;
        end
        return m;
    endfunction

    task automatic send(t_op op, t_word w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{op: op, word: w};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic pause(int unsigned cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE: begin
                out_ready <= 1'b1;
            end
            STALL_COIN: begin
                out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (hold_left == 0) begin
                    hold_val  = !hold_val;
                    hold_left = hold_val ? $urandom_range(1, 6) : $urandom_range(1, 24);
                end
                hold_left--;
                out_ready <= hold_val;
            end
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[bch_15_7_codec] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned burst_left;
        int unsigned kind;
        t_word       w;
        t_op         op;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        send(OP_ENCODE, 15'h0000);
        send(OP_ENCODE, 15'h007F);
        send(OP_ENCODE, 15'h7FFF);
        send(OP_ENCODE, 15'h7F80);
        send(OP_ENCODE, 15'h0001);
        send(OP_ENCODE, 15'h0040);
        send(OP_ENCODE, 15'h552A);
        send(OP_DECODE, 15'h0000);
        send(OP_DECODE, 15'h7FFF);
        send(OP_DECODE, 15'h0001);
        send(OP_DECODE, 15'h4000);
        send(OP_DECODE, codeword(7'h7F));
        send(OP_DECODE, codeword(7'h55));
        send(OP_DECODE, codeword(7'h01) ^ 15'h0001);
        send(OP_DECODE, codeword(7'h40) ^ 15'h4000);
        send(OP_DECODE, codeword(7'h33) ^ 15'h0808);
        send(OP_DECODE, codeword(7'h7F) ^ 15'h4001);
        send(OP_DECODE, codeword(7'h12) ^ 15'h0111);
        send(OP_DECODE, codeword(7'h6C) ^ 15'h2204);
        send(OP_DECODE, codeword(7'h21) ^ 15'h1248);
        send(OP_DECODE, codeword(7'h0F) ^ 15'h7000);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    pause($urandom_range(1, 8));
                end
            end
            burst_left--;
            kind = $urandom_range(0, 12);
            if (kind < 3) begin
                op = OP_ENCODE;
                w  = t_word'($urandom);
            end else begin
                op = OP_DECODE;
                case (kind)
                    3:       w = codeword(t_data'($urandom));
                    4, 5, 6: w = codeword(t_data'($urandom)) ^ error_mask(1);
                    7, 8, 9: w = codeword(t_data'($urandom)) ^ error_mask(2);
                    10:      w = codeword(t_data'($urandom)) ^ error_mask(3);
                    default: w = t_word'($urandom);
                endcase
            end
            send(op, w);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("run covered %0d encode and %0d decode transfers under random stalls,",
                 encodes, decodes);
        $display("%0d of the decodes were predicted uncorrectable", uncorrectable);
        if (fail_count == 0 && pending == 0) begin
            $display("[bch_15_7_codec] OK");
        end else begin
            $display("[bch_15_7_codec] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/bch_pkg.sv
hdl/bch_syn.sv
hdl/bch_trap.sv
hdl/bch_out.sv
hdl/bch_15_7_codec.sv
tb/bch_codec_checker.sv
tb/tb_top.sv
